@@ design/assert_macros.svh @@
// Assertion macros for the checker file totp_chk.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication on the rising clock, disabled during reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication on the rising clock, disabled during reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ design/totp_pkg.sv @@
// Package for the TOTP check: payload structs, state enum, SHA-1 constants.
// No dependencies.
`default_nettype none
package totp_pkg;

  typedef struct packed {
    logic [62:0] current_time;
    logic [19:0] candidate_code;
  } in_t;

  typedef struct packed {
    logic        code_valid;
    logic [19:0] expected_code;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_IH1, ST_IH2, ST_OH1, ST_OH2, ST_MOD, ST_DONE
  } state_t;

  localparam logic [1:0] REG_KF = 2'd0;
  localparam logic [1:0] REG_KL = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;
  localparam logic [1:0] REG_EPOCH = 2'd3;

  localparam logic [15:0] STEP_RESET = 16'd30;
  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;
  localparam logic [159:0] SHA1_IV =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
  localparam logic [63:0] INNER_BITS = 64'd576;
  localparam logic [63:0] OUTER_BITS = 64'd672;

  function automatic logic [31:0] pow10(input int n);
    logic [31:0] v;
    v = 32'd1;
    for (int i = 0; i < n; i++) v = v * 32'd10;
    return v;
  endfunction

endpackage
`default_nettype wire

@@ design/totp_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing; used for the step counter and the code modulus.
`default_nettype none
module totp_div #(
  parameter int NW = 63,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   q_r;
  logic [DW-1:0]   rem_r, den_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;
  logic [DW:0]     rem_sh, diff;

  assign rem_sh = {rem_r, q_r[NW-1]};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_r <= diff[DW-1:0];
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DW-1:0];
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

@@ design/totp_sha1.sv @@
// SHA-1 compression engine, one round per cycle, message schedule in a
// 16-word shift register. Depends on totp_pkg.
`default_nettype none
module totp_sha1
  import totp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [159:0] h_in,
  input  logic [511:0] blk,
  output logic         done,
  output logic [159:0] h_out
);
  logic [31:0]  w_r [16];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [159:0] hs_r;
  logic [6:0]   rnd_r;
  logic         busy_r, done_r;
  logic [31:0]  f, k, t, wn;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = 32'h5A827999;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = 32'h6ED9EBA1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = 32'h8F1BBCDC;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = 32'hCA62C1D6;
    end
    t  = {a_r[26:0], a_r[31:27]} + f + e_r + k + w_r[0];
    wn = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wn = {wn[30:0], wn[31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 1'b1;
        if (rnd_r == 7'd79) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hs_r <= h_in;
      {a_r, b_r, c_r, d_r, e_r} <= h_in;
      for (int i = 0; i < 16; i++) w_r[i] <= blk[511 - 32*i -: 32];
    end else if (busy_r) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
    end
  end

  assign done  = done_r;
  assign h_out = {hs_r[159:128] + a_r, hs_r[127:96] + b_r, hs_r[95:64] + c_r,
                  hs_r[63:32] + d_r, hs_r[31:0] + e_r};
endmodule
`default_nettype wire

@@ design/totp_hmac_sha1_check.sv @@
// Channel  Handshake            Payload
// in_      in_valid/in_ready    in_data  (in_t: current_time, candidate_code)
// out_     out_valid/out_ready  out_data (out_t: code_valid, expected_code)
// cfg_     APB psel/penable     paddr[4:3] selects register, 64-bit data
// One transaction at a time: the divider, four SHA-1 compressions on one
// round unit, the modulus, then the load into the output register; the
// next input is taken only after the result is loaded.
// Input is taken only in idle; the result waits in an output register and a
// new transaction may be taken while it stalls.
// Synchronous active-low reset; no clearing pass. Depends on totp_pkg.
`default_nettype none
module totp_hmac_sha1_check
  import totp_pkg::*;
#(
  parameter int CODE_DIGITS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  localparam logic [31:0] MODV = pow10(CODE_DIGITS);
  localparam int CW = $clog2(MODV);

  state_t        st_r, st_nxt;
  logic [63:0]   kf_r;
  logic [15:0]   kl_r, step_r;
  logic [62:0]   epoch_r;
  logic [19:0]   cand_r;
  logic [63:0]   ctr_r;
  logic [159:0]  inner_r, hin_r;
  logic [511:0]  blk_r;
  logic          sha_go_r, div_go_r, mod_go_r;
  logic [62:0]   num_r;
  logic [15:0]   den_r;
  logic [30:0]   bin_r;
  logic [CW-1:0] code_r;
  logic          out_valid_r;
  out_t          out_r;

  logic          div_done, sha_done, mod_done;
  logic [62:0]   quo;
  logic [15:0]   div_rem;
  logic [30:0]   mod_quo;
  logic [CW-1:0] mod_rem;
  logic [159:0]  h_out;
  logic          in_acc, load_out;
  logic [511:0]  key_blk;
  logic [7:0]    sh;
  logic [159:0]  dsh;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[4:3])
      REG_KF:    prdata = kf_r;
      REG_KL:    prdata = {48'd0, kl_r};
      REG_STEP:  prdata = {48'd0, step_r};
      REG_EPOCH: prdata = {1'b0, epoch_r};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kf_r    <= '0;
      kl_r    <= '0;
      step_r  <= STEP_RESET;
      epoch_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        REG_KF:    kf_r    <= pwdata;
        REG_KL:    kl_r    <= pwdata[15:0];
        REG_STEP:  step_r  <= pwdata[15:0];
        REG_EPOCH: epoch_r <= pwdata[62:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_valid) st_nxt = ST_DIV;
      ST_DIV:  if (div_done) st_nxt = ST_IH1;
      ST_IH1:  if (sha_done) st_nxt = ST_IH2;
      ST_IH2:  if (sha_done) st_nxt = ST_OH1;
      ST_OH1:  if (sha_done) st_nxt = ST_OH2;
      ST_OH2:  if (sha_done) st_nxt = ST_MOD;
      ST_MOD:  if (mod_done) st_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (st_r == ST_IDLE);
    in_acc   = in_ready && in_valid;
    load_out = (st_r == ST_DONE) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      sha_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      mod_go_r    <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      div_go_r <= in_acc;
      sha_go_r <= ((st_r == ST_DIV) && div_done) ||
                  ((st_r == ST_IH1 || st_r == ST_IH2 || st_r == ST_OH1) && sha_done);
      mod_go_r <= (st_r == ST_OH2) && sha_done;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    key_blk = {({kf_r, kl_r} ^ {10{IPAD}}), {54{IPAD}}};
    if (st_r == ST_IH2) key_blk = {({kf_r, kl_r} ^ {10{OPAD}}), {54{OPAD}}};
    sh  = 8'd128 - {1'b0, h_out[3:0], 3'b000};
    dsh = h_out >> sh;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cand_r <= in_data.candidate_code;
      num_r  <= (in_data.current_time >= epoch_r) ? in_data.current_time - epoch_r : '0;
      den_r  <= (step_r == 16'd0) ? 16'd1 : step_r;
    end
    if (st_r == ST_DIV && div_done) begin
      ctr_r <= {1'b0, quo};
      hin_r <= SHA1_IV;
      blk_r <= key_blk;
    end
    if (sha_done) begin
      case (st_r)
        ST_IH1: begin
          hin_r <= h_out;
          blk_r <= {ctr_r, 8'h80, 376'd0, INNER_BITS};
        end
        ST_IH2: begin
          inner_r <= h_out;
          hin_r   <= SHA1_IV;
          blk_r   <= key_blk;
        end
        ST_OH1: begin
          hin_r <= h_out;
          blk_r <= {inner_r, 8'h80, 280'd0, OUTER_BITS};
        end
        ST_OH2:  bin_r <= dsh[30:0];
        default: ;
      endcase
    end
    if (st_r == ST_MOD && mod_done) code_r <= mod_rem;
    if (load_out) begin
      out_r.code_valid    <= (32'(cand_r) == 32'(code_r));
      out_r.expected_code <= 20'(code_r);
    end
  end

  totp_div #(.NW(63), .DW(16)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go_r), .num(num_r), .den(den_r),
    .done(div_done), .quo(quo), .rem(div_rem)
  );

  totp_div #(.NW(31), .DW(CW)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_go_r), .num(bin_r), .den(CW'(MODV)),
    .done(mod_done), .quo(mod_quo), .rem(mod_rem)
  );

  totp_sha1 u_sha (
    .clk(clk), .rst_n(rst_n), .start(sha_go_r), .h_in(hin_r), .blk(blk_r),
    .done(sha_done), .h_out(h_out)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

@@ design/totp_chk.sv @@
// Port-level checker for the TOTP check block, bound to the top level.
// Depends on totp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module totp_chk
  import totp_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);
  `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
  `ASSERT_NXT(a_busy_after_acc, in_valid && in_ready, !in_ready)
  `ASSERT_IMP(a_result_at_idle, $rose(out_valid), in_ready)
endmodule

bind totp_hmac_sha1_check totp_chk u_chk (.*);
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for totp_hmac_sha1_check: HMAC-SHA1 TOTP code check.
// Uses totp_pkg for payload types; a scoreboard class predicts each result.
`timescale 1ns / 1ps
module testbench;
  import totp_pkg::*;

  localparam int LIMIT = 4000000;
  localparam int DRAIN = 600;

  class totp_scoreboard;
    logic [63:0] key_hi;
    logic [15:0] key_lo;
    logic [15:0] step;
    logic [62:0] epoch;
    out_t pending[$];
    string msg;

    function new();
      key_hi = '0;
      key_lo = '0;
      step = STEP_RESET;
      epoch = '0;
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function logic [159:0] compress(logic [159:0] h, logic [511:0] blk);
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
      for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = h[159:128]; b = h[127:96]; c = h[95:64]; d = h[63:32]; e = h[31:0];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d); k = 32'h5A827999;
        end else if (i < 40) begin
          f = b ^ c ^ d; k = 32'h6ED9EBA1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d; k = 32'hCA62C1D6;
        end
        t = rotl(a, 5) + f + e + k + w[i];
        e = d; d = c; c = rotl(b, 30); b = a; a = t;
      end
      return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
    endfunction

    function out_t predict(in_t x);
      logic [63:0] ctr;
      logic [63:0] div;
      logic [79:0] key;
      logic [511:0] blk;
      logic [159:0] h, inner;
      logic [3:0] off;
      logic [31:0] bin, code;
      out_t r;
      div = (step == 0) ? 64'd1 : {48'd0, step};
      ctr = (x.current_time >= epoch) ? ({1'b0, x.current_time} - {1'b0, epoch}) / div : 64'd0;
      key = {key_hi, key_lo};
      blk = {key ^ {10{IPAD}}, {54{IPAD}}};
      h = compress(SHA1_IV, blk);
      h = compress(h, {ctr, 8'h80, 376'd0, INNER_BITS});
      inner = h;
      blk = {key ^ {10{OPAD}}, {54{OPAD}}};
      h = compress(SHA1_IV, blk);
      h = compress(h, {inner, 8'h80, 280'd0, OUTER_BITS});
      off = h[3:0];
      bin = h[159 - 8*off -: 32] & 32'h7FFFFFFF;
      code = bin % 32'd1000000;
      r.code_valid = ({12'd0, x.candidate_code} == code);
      r.expected_code = code[19:0];
      return r;
    endfunction

    function void note_input(in_t x);
      pending.push_back(predict(x));
    endfunction

    function bit check_result(out_t got);
      out_t exp_r;
      if (pending.size() == 0) begin
        msg = $sformatf("unexpected result %0d/%0d", got.code_valid, got.expected_code);
        return 0;
      end
      exp_r = pending.pop_front();
      if (got.code_valid !== exp_r.code_valid || got.expected_code !== exp_r.expected_code) begin
        msg = $sformatf("mismatch: got valid=%0d code=%0d, want valid=%0d code=%0d",
                        got.code_valid, got.expected_code, exp_r.code_valid,
                        exp_r.expected_code);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t in_data;
  out_t out_data;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [63:0] pwdata, prdata;

  totp_scoreboard sb;
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  int hold_req = 0;

  totp_hmac_sha1_check dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic report(string s);
    errors++;
    $display("ERROR @%0t: %s", $realtime, s);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("totp_hmac_sha1_check verification failed");
      $finish;
    end
  end

  // receiver: random stalls, long hold-off on request
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (hold_req > 0 && hold_cnt == 0) hold_cnt = hold_req;
    if (hold_cnt > 0) begin
      hold_cnt--;
      if (hold_cnt == 0) hold_req = 0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (!sb.check_result(out_data)) report(sb.msg);
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_KF: sb.key_hi = val;
      REG_KL: sb.key_lo = val[15:0];
      REG_STEP: sb.step = val[15:0];
      REG_EPOCH: sb.epoch = val[62:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic configure(logic [63:0] kh, logic [15:0] kl, logic [15:0] st,
                           logic [62:0] ep);
    drain();
    cfg_write(REG_KF, kh);
    cfg_write(REG_KL, {48'd0, kl});
    cfg_write(REG_STEP, {48'd0, st});
    cfg_write(REG_EPOCH, {1'b0, ep});
  endtask

  task automatic send(in_t x);
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    sb.note_input(x);
    if (!quiet) begin
      while ($urandom_range(99) < 18) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  function automatic in_t mk(logic [62:0] t, logic [19:0] c);
    in_t x;
    x.current_time = t;
    x.candidate_code = c;
    return x;
  endfunction

  function automatic logic [62:0] rand_time();
    case ($urandom_range(3))
      0: return 63'({$urandom, $urandom});
      1: return sb.epoch + 63'($urandom_range(200000));
      2: return 63'($urandom);
      default: return sb.epoch - 63'($urandom_range(100));
    endcase
  endfunction

  task automatic random_items(int n);
    in_t x;
    for (int i = 0; i < n; i++) begin
      x = mk(rand_time(), 20'($urandom));
      case ($urandom_range(3))
        0, 1: x.candidate_code = sb.predict(x).expected_code;
        2: x.candidate_code = 20'($urandom_range(999999));
        default: ;
      endcase
      send(x);
    end
  endtask

  initial begin
    in_t x;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0; in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset configuration
    send(mk('0, '0));
    send(mk('1, 20'd999999));
    send(mk(63'd59, 20'hFFFFF));
    x = mk(63'd1111111109, '0);
    x.candidate_code = sb.predict(x).expected_code;
    send(x);
    send(mk(63'd1234567890, 20'd1000000));

    configure('1, 16'hFFFF, 16'd1, '0);
    send(mk('1, '0));
    x = mk(63'd5, '0);
    x.candidate_code = sb.predict(x).expected_code;
    send(x);
    send(mk(63'h2AAAAAAAAAAAAAAA, 20'h55555));

    configure(64'h3132333435363738, 16'h3930, 16'hFFFF, '1);
    send(mk('0, '0));
    send(mk('1, 20'hAAAAA));
    send(mk(63'h7FFFFFFFFFFFFFFE, 20'd1));

    configure(64'h0123456789ABCDEF, 16'hFEDC, 16'd0, 63'd1000);
    send(mk(63'd999, '0));
    send(mk(63'd1000, '0));
    send(mk(63'd1001, '0));
    send(mk(63'd5000, 20'd999999));

    configure({$urandom, $urandom}, 16'($urandom), STEP_RESET, 63'd0);
    // long receiver hold-off while the sender keeps offering
    hold_req = 3000;
    random_items(10);
    // sender pause until everything is back
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    random_items(40);

    for (int ph = 0; ph < 5; ph++) begin
      configure({$urandom, $urandom}, 16'($urandom),
                (ph == 2) ? 16'd1 : 16'($urandom_range(65535, 1)),
                (ph == 3) ? '1 : 63'({$urandom, $urandom}));
      if (ph == 1) quiet = 1;
      random_items(200);
      quiet = 0;
    end

    drain();
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("totp_hmac_sha1_check verification clean");
    end else begin
      $display("totp_hmac_sha1_check verification failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+design
design/totp_pkg.sv
design/totp_div.sv
design/totp_sha1.sv
design/totp_hmac_sha1_check.sv
design/totp_chk.sv
tb/testbench.sv
